/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Both sample on clk and are disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CMPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CMPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cmpm_pkg.sv */
// ----------------------------------------------------------------------------
// cmpm_pkg
// Types and constants shared by the circular masked pseudocolor map.
// ----------------------------------------------------------------------------
package cmpm_pkg;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TABLE = 1'b1;

  // Pixel constants
  localparam logic [31:0] WHITE_PIXEL  = 32'hFFFF_FFFF;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  // Configuration port
  localparam int unsigned PADDR_W = 4;

  typedef enum logic [1:0] {
    REG_IMAGE_SIZE  = 2'd0,
    REG_NUM_COLORS  = 2'd1,
    REG_MIN_LEVEL   = 2'd2,
    REG_LEVEL_SCALE = 2'd3
  } cfg_reg_t;

  localparam logic [10:0] IMAGE_SIZE_RST  = 11'd256;
  localparam logic [8:0]  NUM_COLORS_RST  = 9'd256;
  localparam logic [31:0] MIN_LEVEL_RST   = 32'd0;
  localparam logic [31:0] LEVEL_SCALE_RST = 32'h0001_0000;

  typedef struct packed {
    logic [10:0]        image_size;
    logic [8:0]         num_colors;
    logic signed [31:0] min_level;
    logic [31:0]        level_scale;
  } cfg_regs_t;

  // Input transfer payload
  typedef struct packed {
    logic               kind;
    logic signed [31:0] sample_value;
    logic [7:0]         table_index;
    logic [23:0]        table_rgb;
  } in_item_t;

  // Result transfer payload
  typedef struct packed {
    logic [31:0] pixel_rgba;
    logic        end_of_image;
  } out_item_t;

  // Pipeline occupancy, for checks at the top level
  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
    logic s2_table;
    logic s3_valid;
  } pipe_status_t;

endpackage

/* src/cmpm_ram.sv */
// ----------------------------------------------------------------------------
// cmpm_ram
// Generic single-port RAM with clock enable and registered read data.
// ----------------------------------------------------------------------------
module cmpm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-before-write on the same port
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

/* src/cmpm_cfg.sv */
// ----------------------------------------------------------------------------
// cmpm_cfg
// APB register file: image size, color count, minimum level, level scale.
// ----------------------------------------------------------------------------
module cmpm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cmpm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output cmpm_pkg::cfg_regs_t          regs
);

  import cmpm_pkg::*;

  cfg_regs_t regs_r;
  cfg_reg_t  sel;
  logic      wr_en;

  assign pready = 1'b1;
  assign sel    = cfg_reg_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign regs   = regs_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.image_size  <= IMAGE_SIZE_RST;
      regs_r.num_colors  <= NUM_COLORS_RST;
      regs_r.min_level   <= MIN_LEVEL_RST;
      regs_r.level_scale <= LEVEL_SCALE_RST;
    end else if (wr_en) begin
      case (sel)
        REG_IMAGE_SIZE:  regs_r.image_size  <= pwdata[10:0];
        REG_NUM_COLORS:  regs_r.num_colors  <= pwdata[8:0];
        REG_MIN_LEVEL:   regs_r.min_level   <= pwdata;
        REG_LEVEL_SCALE: regs_r.level_scale <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (sel)
      REG_IMAGE_SIZE:  prdata = 32'(regs_r.image_size);
      REG_NUM_COLORS:  prdata = 32'(regs_r.num_colors);
      REG_MIN_LEVEL:   prdata = regs_r.min_level;
      REG_LEVEL_SCALE: prdata = regs_r.level_scale;
      default:         prdata = 32'd0;
    endcase
  end

endmodule

/* src/cmpm_raster.sv */
// ----------------------------------------------------------------------------
// cmpm_raster
// Column and row counters over the square image, with the saturated size.
// ----------------------------------------------------------------------------
module cmpm_raster #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [10:0]                  image_size,
  input  logic                         step,
  output logic [$clog2(MAX_DIM)-1:0]   col,
  output logic [$clog2(MAX_DIM)-1:0]   row,
  output logic [$clog2(MAX_DIM+1)-1:0] n_eff,
  output logic                         last_pixel
);

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [DW-1:0] n_m1;
  logic          row_end;
  logic          img_end;

  // Size clamped to [2, MAX_DIM]
  always_comb begin
    if (image_size < 11'd2) begin
      n_eff = DW'(2);
    end else if (32'(image_size) > MAX_DIM) begin
      n_eff = DW'(MAX_DIM);
    end else begin
      n_eff = DW'(image_size);
    end
  end

  assign n_m1       = n_eff - DW'(1);
  assign row_end    = DW'(col_r) >= n_m1;
  assign img_end    = DW'(row_r) >= n_m1;
  assign last_pixel = row_end & img_end;
  assign col        = col_r;
  assign row        = row_r;

  // Counter advance
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = img_end ? '0 : row_r + CW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

/* src/cmpm_pipe.sv */
// ----------------------------------------------------------------------------
// cmpm_pipe
// Three-stage pixel pipeline: squares and level product, circle test and bin
// clamp with table access, then the packed pixel.
// ----------------------------------------------------------------------------
module cmpm_pipe #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned MAX_COLORS = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmpm_pkg::cfg_regs_t          regs,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cmpm_pkg::in_item_t           in_data,
  input  logic [$clog2(MAX_DIM)-1:0]   col,
  input  logic [$clog2(MAX_DIM)-1:0]   row,
  input  logic [$clog2(MAX_DIM+1)-1:0] n_eff,
  input  logic                         last_pixel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cmpm_pkg::out_item_t          out_data,
  output cmpm_pkg::pipe_status_t       status
);

  import cmpm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned SW = DW + 2;          // signed centre offset
  localparam int unsigned QW = 2 * SW - 2;      // square of an offset
  localparam int unsigned AW = $clog2(MAX_COLORS);
  localparam logic [AW-1:0] TOP_BIN = AW'(MAX_COLORS - 1);

  // Handshake between stages
  logic adv1, adv2, adv3;

  // Stage 1: accepted item and its raster position
  logic          v1_r;
  in_item_t      s1_item_r;
  logic [CW-1:0] s1_col_r, s1_row_r;
  logic [DW-1:0] s1_n_r;
  logic          s1_eoi_r;

  // Stage 2: squares and scaled level
  logic          v2_r;
  logic          s2_kind_r;
  logic [7:0]    s2_tidx_r;
  logic [23:0]   s2_trgb_r;
  logic          s2_eoi_r;
  logic [QW-1:0] s2_dx2_r, s2_dy2_r;
  logic [2*DW-1:0] s2_nn_r;
  logic [31:0]   s2_prod_hi_r;
  logic          s2_dpos_r;

  // Stage 3: result
  logic          v3_r;
  logic          s3_inside_r;
  logic          s3_eoi_r;
  logic [23:0]   rgb_rd;

  // Stage 1 datapath
  logic signed [SW-1:0]   dx, dy;
  logic signed [2*SW-1:0] dx_sq, dy_sq;
  logic [2*DW-1:0]        nn;
  logic signed [32:0]     diff;
  logic                   dpos;
  logic [63:0]            prod;

  // Stage 2 datapath
  logic [QW:0]   rad_sq;
  logic          in_circle;
  logic [AW-1:0] ncm1;
  logic [AW-1:0] bin;
  logic          tbl_ok;
  logic          ram_we;
  logic [AW-1:0] ram_addr;

  assign adv3     = !v3_r | out_ready;
  assign adv2     = !v2_r | adv3;
  assign adv1     = !v1_r | adv2;
  assign in_ready = adv1;

  // Offsets from the image centre, doubled so they stay integer
  assign dx    = $signed(SW'({s1_col_r, 1'b0}) - SW'(s1_n_r) + SW'(1'b1));
  assign dy    = $signed(SW'({s1_row_r, 1'b0}) - SW'(s1_n_r) + SW'(1'b1));
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign nn    = (2 * DW)'(s1_n_r) * (2 * DW)'(s1_n_r);

  // Level above minimum; a positive 33-bit difference fits 32 bits
  assign diff = {s1_item_r.sample_value[31], s1_item_r.sample_value}
              - {regs.min_level[31], regs.min_level};
  assign dpos = !diff[32] && (diff != 33'sd0);
  assign prod = {32'd0, diff[31:0]} * {32'd0, regs.level_scale};

  // Circle test
  assign rad_sq    = {1'b0, s2_dx2_r} + {1'b0, s2_dy2_r};
  assign in_circle = rad_sq <= (QW + 1)'(s2_nn_r);

  // Highest usable bin from the color count, clamped to [1, MAX_COLORS]
  always_comb begin
    if (regs.num_colors == 9'd0) begin
      ncm1 = '0;
    end else if (32'(regs.num_colors) > MAX_COLORS) begin
      ncm1 = TOP_BIN;
    end else begin
      ncm1 = AW'(regs.num_colors - 9'd1);
    end
  end

  // Bin select with clamp
  always_comb begin
    if (!s2_dpos_r) begin
      bin = '0;
    end else if (s2_prod_hi_r > 32'(ncm1)) begin
      bin = ncm1;
    end else begin
      bin = AW'(s2_prod_hi_r);
    end
  end

  // Table port: writes and reads share the stage 2 slot
  assign tbl_ok   = 32'(s2_tidx_r) < MAX_COLORS;
  assign ram_we   = v2_r && (s2_kind_r == KIND_TABLE) && tbl_ok;
  assign ram_addr = (s2_kind_r == KIND_TABLE) ? AW'(s2_tidx_r) : bin;

  cmpm_ram #(
    .WIDTH (24),
    .DEPTH (MAX_COLORS)
  ) u_table (
    .clk   (clk),
    .en    (adv3),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (s2_trgb_r),
    .rdata (rgb_rd)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r && (s2_kind_r == KIND_PIXEL);
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_item_r <= in_data;
      s1_col_r  <= col;
      s1_row_r  <= row;
      s1_n_r    <= n_eff;
      s1_eoi_r  <= last_pixel;
    end
    if (adv2) begin
      s2_kind_r    <= s1_item_r.kind;
      s2_tidx_r    <= s1_item_r.table_index;
      s2_trgb_r    <= s1_item_r.table_rgb;
      s2_eoi_r     <= s1_eoi_r;
      s2_dx2_r     <= dx_sq[QW-1:0];
      s2_dy2_r     <= dy_sq[QW-1:0];
      s2_nn_r      <= nn;
      s2_prod_hi_r <= prod[63:32];
      s2_dpos_r    <= dpos;
    end
    if (adv3) begin
      s3_inside_r <= in_circle;
      s3_eoi_r    <= s2_eoi_r;
    end
  end

  // Result
  assign out_valid               = v3_r;
  assign out_data.pixel_rgba     = s3_inside_r ? {ALPHA_OPAQUE, rgb_rd} : WHITE_PIXEL;
  assign out_data.end_of_image   = s3_eoi_r;

  assign status.s1_valid = v1_r;
  assign status.s2_valid = v2_r;
  assign status.s2_table = s2_kind_r == KIND_TABLE;
  assign status.s3_valid = v3_r;

endmodule

/* src/circular_masked_pseudocolor_map_top.sv */
// A pixel sample passes through the stage 1, stage 2 and stage 3 registers before its result is offered.
// Throughput: one item per cycle while the output is not stalled; the table port takes one write or read per cycle.
// Table writes occupy one pipeline slot and give no result.
// Reset (synchronous, rst_n low) clears the raster counters, pipeline valids and
// registers to their defaults; color table contents are undefined until written.
// ----------------------------------------------------------------------------
// circular_masked_pseudocolor_map_top
// Maps a raster of Q16.16 samples through a loadable color table, masking
// everything outside the inscribed circle to white.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module circular_masked_pseudocolor_map_top #(
  parameter int unsigned MAX_COLORS = 256,
  parameter int unsigned MAX_DIM    = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input transfers
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cmpm_pkg::in_item_t           in_data,
  // Result transfers
  output logic                         out_valid,
  input  logic                         out_ready,
  output cmpm_pkg::out_item_t          out_data,
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cmpm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import cmpm_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);

  cfg_regs_t     regs;
  pipe_status_t  status;
  logic [CW-1:0] col, row;
  logic [DW-1:0] n_eff;
  logic          last_pixel;
  logic          pixel_step;
  logic          full_stall;
  logic          tbl_retire;
  logic          img_done;
  logic          at_origin;

  assign pixel_step = in_valid && in_ready && (in_data.kind == KIND_PIXEL);

  cmpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  cmpm_raster #(
    .MAX_DIM (MAX_DIM)
  ) u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .image_size (regs.image_size),
    .step       (pixel_step),
    .col        (col),
    .row        (row),
    .n_eff      (n_eff),
    .last_pixel (last_pixel)
  );

  cmpm_pipe #(
    .MAX_DIM    (MAX_DIM),
    .MAX_COLORS (MAX_COLORS)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .regs       (regs),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .col        (col),
    .row        (row),
    .n_eff      (n_eff),
    .last_pixel (last_pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .status     (status)
  );

  // Terms for the checks below
  assign full_stall = status.s1_valid && status.s2_valid && status.s3_valid && !out_ready;
  assign tbl_retire = status.s2_valid && status.s2_table && (!out_valid || out_ready);
  assign img_done   = pixel_step && last_pixel;
  assign at_origin  = (col == '0) && (row == '0);

  // Backpressure only when every stage is full and the output is stalled
  `CMPM_ASSERT_IMP(a_ready_only_when_full, !in_ready, full_stall, "input stalled early")

  // A table write moving on leaves no result behind
  `CMPM_ASSERT_NXT(a_table_no_result, tbl_retire, !out_valid, "table write produced a result")

  // The last pixel of an image wraps both counters
  `CMPM_ASSERT_NXT(a_image_wrap, img_done, at_origin, "counters did not wrap at end of image")

endmodule

/* dv/tb_circular_masked_pseudocolor_map_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_masked_pseudocolor_map_top
// Streams color table writes and raster samples into the pseudocolor map and
// checks every pixel against a cycle-free model of the circular mask, the bin
// arithmetic and the table lookup. Directed corner cases come first, then
// random phases of whole and partial images under changing register settings,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_circular_masked_pseudocolor_map_top;
  import cmpm_pkg::*;

  localparam int unsigned MAX_COLORS     = 256;
  localparam int unsigned MAX_DIM        = 1024;
  localparam int unsigned RANDOM_ITEMS   = 370;
  localparam int unsigned LONG_STALL     = 80;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_PRINTS     = 20;
  localparam longint     SAMPLE_MAX      = 64'sd2147483647;
  localparam longint     SAMPLE_MIN      = -64'sd2147483648;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // Model state: register copies, raster position, color table
  logic [10:0]           size_reg = IMAGE_SIZE_RST;
  logic [8:0]            colors_reg = NUM_COLORS_RST;
  logic signed [31:0]    min_reg = MIN_LEVEL_RST;
  logic [31:0]           scale_reg = LEVEL_SCALE_RST;
  int unsigned           col_pos = 0;
  int unsigned           row_pos = 0;
  logic [23:0]           lut_copy [0:MAX_COLORS-1];

  in_item_t              pending_items [$];
  out_item_t             expected_pixels [$];
  int unsigned           error_count = 0;
  int unsigned           tx_wait = 0;
  int unsigned           rx_wait = 0;
  int unsigned           stall_req = 0;
  int unsigned           stall_ack = 0;
  int unsigned           quiet_cycles = 0;
  bit                    no_idle = 1'b0;

  circular_masked_pseudocolor_map_top #(
    .MAX_COLORS(MAX_COLORS),
    .MAX_DIM   (MAX_DIM)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Per-transfer wait, zero throughout a no-idle stretch
  function automatic int unsigned draw_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic int unsigned eff_size();
    if (size_reg < 2) return 2;
    if (size_reg > MAX_DIM) return MAX_DIM;
    return 32'(size_reg);
  endfunction

  function automatic int unsigned eff_colors();
    if (colors_reg < 1) return 1;
    if (colors_reg > MAX_COLORS) return MAX_COLORS;
    return 32'(colors_reg);
  endfunction

  // Expected pixel for one sample; advances the raster position
  function automatic out_item_t map_sample(input logic signed [31:0] sample);
    int unsigned n;
    int unsigned last_bin;
    longint      dx;
    longint      dy;
    longint      d;
    logic [63:0] prod;
    logic [31:0] bin;
    out_item_t   res;
    n        = eff_size();
    last_bin = eff_colors() - 1;
    dx = 2 * longint'(col_pos) - longint'(n) + 1;
    dy = 2 * longint'(row_pos) - longint'(n) + 1;
    if (dx * dx + dy * dy <= longint'(n) * longint'(n)) begin
      d = longint'(sample) - longint'(min_reg);
      if (d <= 0) begin
        bin = '0;
      end else begin
        // d never exceeds 32 bits, so the product fits in 64
        prod = {32'd0, d[31:0]} * {32'd0, scale_reg};
        bin  = prod[63:32];
        if (bin > last_bin) bin = last_bin;
      end
      res.pixel_rgba = {ALPHA_OPAQUE, lut_copy[bin[7:0]]};
    end else begin
      res.pixel_rgba = WHITE_PIXEL;
    end
    res.end_of_image = 1'b0;
    // Raster advance; oversized counts end the row or image at once
    if (col_pos >= n - 1) begin
      col_pos = 0;
      if (row_pos >= n - 1) begin
        row_pos = 0;
        res.end_of_image = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  // Sample drawn around the active level range, with some full-range noise
  function automatic logic signed [31:0] draw_sample();
    longint span;
    longint pick;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: return min_reg + 32'($urandom_range(0, 4)) - 32'd2;
      default: begin
        if (scale_reg == 0) begin
          span = 64'sh1_0000_0000;
        end else begin
          span = (longint'(eff_colors()) <<< 32) / longint'({32'd0, scale_reg});
        end
        if (span > 64'sh1_0000_0000) span = 64'sh1_0000_0000;
        pick = longint'(min_reg) - span / 16
             + (longint'({$urandom, $urandom} >> 1) % (span + span / 8 + 1));
        if (pick > SAMPLE_MAX) pick = SAMPLE_MAX;
        if (pick < SAMPLE_MIN) pick = SAMPLE_MIN;
        return pick[31:0];
      end
    endcase
  endfunction

  task automatic push_pixel(input logic signed [31:0] sample);
    in_item_t item;
    item.kind         = KIND_PIXEL;
    item.sample_value = sample;
    item.table_index  = 8'($urandom);
    item.table_rgb    = 24'($urandom);
    pending_items.push_back(item);
  endtask

  task automatic push_table(input logic [7:0] index, input logic [23:0] rgb);
    in_item_t item;
    item.kind         = KIND_TABLE;
    item.sample_value = $urandom;
    item.table_index  = index;
    item.table_rgb    = rgb;
    pending_items.push_back(item);
  endtask

  // Setup and access cycle; the register takes the value on the access edge
  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_IMAGE_SIZE:  size_reg   = value[10:0];
      REG_NUM_COLORS:  colors_reg = value[8:0];
      REG_MIN_LEVEL:   min_reg    = value;
      REG_LEVEL_SCALE: scale_reg  = value;
      default: ;
    endcase
  endtask

  // Block until every queued transfer is done and every pixel is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS)
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait  <= 0;
    end else if (!in_valid || in_ready) begin
      if (tx_wait > 0) begin
        in_valid <= 1'b0;
        tx_wait  <= tx_wait - 1;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        tx_wait  <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output receiver with random stalls and an on-demand long hold-off
  always @(posedge clk) begin : receiver
    int unsigned w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else begin
      w = rx_wait;
      if (stall_req != stall_ack) begin
        w = LONG_STALL;
        stall_ack <= stall_req;
      end else if (out_valid && out_ready) begin
        w = draw_wait();
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        rx_wait   <= w - 1;
      end else begin
        out_ready <= 1'b1;
        rx_wait   <= 0;
      end
    end
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_data.kind == KIND_TABLE) lut_copy[in_data.table_index] = in_data.table_rgb;
        else expected_pixels.push_back(map_sample(in_data.sample_value));
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel", out_data.pixel_rgba, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_rgba !== want.pixel_rgba)
            report_mismatch("pixel_rgba", out_data.pixel_rgba, want.pixel_rgba);
          if (out_data.end_of_image !== want.end_of_image)
            report_mismatch("end_of_image", 32'(out_data.end_of_image),
                            32'(want.end_of_image));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("tb_circular_masked_pseudocolor_map_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    int unsigned n_pix;
    logic [31:0] v;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Load the whole table so no lookup ever hits an unwritten entry
    for (int i = 0; i < MAX_COLORS; i++) push_table(8'(i), 24'($urandom));
    // Reset settings: the top-left corner of a 256 image is outside the circle
    push_pixel(32'sh0000_0000);
    push_pixel(32'sh0001_8000);
    push_pixel($urandom);
    wait_idle();

    // Two-by-two image, every pixel inside; counters left over from above
    cfg_write(REG_IMAGE_SIZE, 32'd2);
    push_pixel(32'sh0000_0000);   // at the minimum
    push_pixel(32'sh8000_0000);   // far below the minimum
    push_pixel(32'sh7FFF_FFFF);   // far above, clamped to the top bin
    push_pixel(32'sh0001_0000);   // one bin up
    push_table(8'd0, 24'h000000);
    push_table(8'd255, 24'hFFFFFF);
    push_pixel(32'sh00FF_FFFF);   // just under the top bin edge
    push_pixel(32'sh0100_0000);   // exactly past the last bin
    wait_idle();

    // Lowest minimum, steepest scale, zero colors saturating to one
    cfg_write(REG_MIN_LEVEL, 32'h8000_0000);
    cfg_write(REG_LEVEL_SCALE, 32'hFFFF_FFFF);
    cfg_write(REG_NUM_COLORS, 32'h0000_0000);
    push_pixel(32'sh7FFF_FFFF);
    push_pixel(32'sh8000_0000);
    wait_idle();
    // Color count masked to 511, saturating to the table size
    cfg_write(REG_NUM_COLORS, 32'hFFFF_FFFF);
    push_pixel(32'sh8000_0001);
    push_pixel(32'sh8000_0002);
    push_pixel(32'sh7FFF_FFFF);
    wait_idle();

    // Highest minimum and zero scale
    cfg_write(REG_MIN_LEVEL, 32'h7FFF_FFFF);
    cfg_write(REG_LEVEL_SCALE, 32'h0000_0000);
    push_pixel(32'sh7FFF_FFFF);
    push_pixel(32'sh0000_0000);
    wait_idle();

    // Image size below the range, then above it, then zero
    cfg_write(REG_IMAGE_SIZE, 32'hFFFF_F801);
    cfg_write(REG_MIN_LEVEL, 32'h0000_0000);
    cfg_write(REG_LEVEL_SCALE, 32'h0001_0000);
    cfg_write(REG_NUM_COLORS, 32'd256);
    push_pixel(32'sh0003_0000);
    push_pixel(32'sh0000_8000);
    wait_idle();
    cfg_write(REG_IMAGE_SIZE, 32'h0000_07FF);
    push_pixel(32'sh0005_0000);
    push_pixel(32'sh0080_0000);
    wait_idle();
    cfg_write(REG_IMAGE_SIZE, 32'h0000_0000);
    push_pixel(32'sh0002_0000);
    push_pixel(32'sh00FF_0000);
    wait_idle();

    // Random phases
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 19))
          0:          v = $urandom_range(0, 1);
          1:          v = $urandom_range(1024, 2047);
          2, 3, 4, 5: v = $urandom_range(9, 20);
          default:    v = $urandom_range(2, 8);
        endcase
        cfg_write(REG_IMAGE_SIZE, ($urandom & ~32'h7FF) | v);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0:          v = $urandom_range(0, 1);
          1:          v = $urandom_range(256, 511);
          2, 3, 4:    v = $urandom_range(2, 16);
          default:    v = $urandom_range(1, 256);
        endcase
        cfg_write(REG_NUM_COLORS, ($urandom & ~32'h1FF) | v);
      end
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 1) == 0) v = $urandom;
        else v = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
        cfg_write(REG_MIN_LEVEL, v);
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0:          v = 32'h0000_0000;
          1:          v = 32'hFFFF_FFFF;
          2:          v = 32'h0000_0001;
          3, 4, 5:    v = $urandom;
          default:    v = $urandom_range(1, 32'h0010_0000);
        endcase
        cfg_write(REG_LEVEL_SCALE, v);
      end

      n = eff_size();
      if (n > 20) n_pix = $urandom_range(5, 30);
      else if (n > 8) n_pix = $urandom_range(1, 3 * n);
      else n_pix = n * n * $urandom_range(1, 2) + $urandom_range(0, n);

      // Once: hold the output off while the sender keeps offering pixels
      if (phase == 1) begin
        no_idle = 1'b1;
        n_pix   = 40;
        stall_req++;
      end

      for (int k = 0; k < n_pix; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_table(8'($urandom), 24'($urandom));
          sent++;
        end
        push_pixel(draw_sample());
      end
      sent += n_pix;
      phase++;
      wait_idle();
    end

    if (expected_pixels.size() != 0)
      report_mismatch("pixels never delivered", expected_pixels.size(), '0);
    if (error_count == 0) begin
      $display("tb_circular_masked_pseudocolor_map_top OK");
    end else begin
      $display("tb_circular_masked_pseudocolor_map_top NOT OK");
    end
    $finish;
  end

endmodule
